@@ hw/rtl/pta_pkg.sv @@
package pta_pkg;

	localparam int TABLE_ENTRIES = 4;
	localparam int NGAPS         = TABLE_ENTRIES + 1;
	localparam int SLOT_W        = 2;
	localparam int BYTE_W        = 31;
	localparam int HDR_W         = 16;
	localparam int NAME_W        = 64;
	localparam int END_W         = BYTE_W + 1;
	localparam int GAP_W         = END_W + 2;
	localparam int NEED_W        = BYTE_W + 20;
	localparam int CFG_IDX_W     = 1;
	localparam int IN_W          = 104;
	localparam int OUT_W         = 72;

	localparam logic [CFG_IDX_W-1:0] CFG_DISK   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b1;

	localparam logic [HDR_W-1:0] HEADER_RESET = 16'd512;

	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] UNIT_B   = 2'd0;
	localparam logic [1:0] UNIT_KIB = 2'd1;
	localparam logic [1:0] UNIT_MIB = 2'd2;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD       = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_EXTENDED  = 3'd4,
		ST_NO_SPACE  = 3'd5,
		ST_NOT_FOUND = 3'd6
	} status_t;

	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] size_value;
		logic [1:0]        size_unit;
		logic              kind;
		logic [1:0]        fit_mode;
		logic [NAME_W-1:0] name_key;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] length_bytes;
		logic              found_kind;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] start;
		logic [BYTE_W-1:0] length;
		logic              ext;
		logic [NAME_W-1:0] name;
	} tbl_wr_t;

	typedef struct packed {
		logic [TABLE_ENTRIES-1:0]             live;
		logic [TABLE_ENTRIES-1:0][BYTE_W-1:0] start;
		logic [TABLE_ENTRIES-1:0][BYTE_W-1:0] length;
		logic [TABLE_ENTRIES-1:0]             ext;
		logic [TABLE_ENTRIES-1:0][NAME_W-1:0] name;
		logic [BYTE_W-1:0]                    disk;
		logic [HDR_W-1:0]                     header;
	} tbl_t;

endpackage

@@ hw/rtl/partition_table_fit_allocator.sv @@
// Partition table allocator with a four-entry table. Each request item passes through the
// decision stage that sits between the input register and the result register,
// so one item is accepted per clock while the result side keeps up, and its result
// is captured in the result register once the output side can take it.
// The table update of a create and the capture of its result happen at the same edge, so
// the next item already sees the new entry. The table is empty after reset; disk size
// and header size must be written on the cfg port while no item is in flight; not enforced.
module partition_table_fit_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// size_value[30:0], size_unit[32:31], kind[33], fit_mode[35:34], name_key[99:36]
	input  logic [pta_pkg::IN_W-1:0]      s_tdata,
	// operation[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[2:0], slot[4:3], start_byte[35:5], length_bytes[66:36], found_kind[67]
	output logic [pta_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pta_pkg::BYTE_W-1:0]    cfg_data
);

	pta_pkg::req_t    req_s1;
	logic             valid_s1;
	pta_pkg::res_t    res;
	pta_pkg::res_t    res_q;
	logic             out_valid_q;
	pta_pkg::tbl_wr_t wr_eng;
	pta_pkg::tbl_wr_t wr;
	pta_pkg::tbl_t    tbl;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.operation  <= s_tuser;
			req_s1.size_value <= s_tdata[30:0];
			req_s1.size_unit  <= s_tdata[32:31];
			req_s1.kind       <= s_tdata[33];
			req_s1.fit_mode   <= s_tdata[35:34];
			req_s1.name_key   <= s_tdata[99:36];
		end
	end

	pta_engine u_engine (
		.req (req_s1),
		.tbl (tbl),
		.res (res),
		.wr  (wr_eng)
	);

	always_comb begin
		wr    = wr_eng;
		wr.en = wr_eng.en && advance;
	end

	pta_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.tbl       (tbl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, res_q.found_kind, res_q.length_bytes, res_q.start_byte,
		res_q.slot, res_q.status};

endmodule

@@ hw/rtl/pta_table.sv @@
module pta_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pta_pkg::BYTE_W-1:0]    cfg_data,
	input  pta_pkg::tbl_wr_t              wr,
	output pta_pkg::tbl_t                 tbl
);

	pta_pkg::tbl_t tbl_q;

	assign tbl = tbl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q <= '{live: '0, start: '0, length: '0, ext: '0, name: '0, disk: '0,
				header: pta_pkg::HEADER_RESET};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pta_pkg::CFG_DISK:   tbl_q.disk   <= cfg_data;
					pta_pkg::CFG_HEADER: tbl_q.header <= cfg_data[pta_pkg::HDR_W-1:0];
					default: ;
				endcase
			end
			if (wr.en) begin
				tbl_q.live[wr.slot]   <= 1'b1;
				tbl_q.start[wr.slot]  <= wr.start;
				tbl_q.length[wr.slot] <= wr.length;
				tbl_q.ext[wr.slot]    <= wr.ext;
				tbl_q.name[wr.slot]   <= wr.name;
			end
		end
	end

endmodule

@@ hw/rtl/pta_engine.sv @@
module pta_engine (
	input  pta_pkg::req_t    req,
	input  pta_pkg::tbl_t    tbl,
	output pta_pkg::res_t    res,
	output pta_pkg::tbl_wr_t wr
);

	localparam int N = pta_pkg::TABLE_ENTRIES;
	localparam int G = pta_pkg::NGAPS;

	logic [pta_pkg::NEED_W-1:0] need;
	logic [N-1:0][N-1:0]        bef;
	logic [G-1:0][G-1:0]        prec;
	logic [G-1:0][pta_pkg::END_W-1:0] gstart;
	logic [G-1:0][pta_pkg::END_W-1:0] gend;
	logic [G-1:0][pta_pkg::GAP_W-1:0] gsize;
	logic [G-1:0][pta_pkg::END_W:0]   gsz;
	logic [G-1:0]               gok;
	logic [G-1:0]               win;
	logic [pta_pkg::END_W-1:0]  pick_start;
	logic                       any_fit;
	logic                       dup, full, ext_exists, found;
	logic [pta_pkg::SLOT_W-1:0] free_slot, hit_slot;
	logic                       free_seen;

	// scaled size, unit code three counts as kibibytes
	always_comb begin
		case (req.size_unit)
			pta_pkg::UNIT_B:   need = {20'b0, req.size_value};
			pta_pkg::UNIT_MIB: need = {req.size_value, 20'b0};
			default:           need = {10'b0, req.size_value, 10'b0};
		endcase
	end

	// table order: by start, then by slot
	always_comb begin
		for (int i = 0; i < N; i++)
			for (int j = 0; j < N; j++)
				bef[i][j] = (tbl.start[i] < tbl.start[j]) ||
					((tbl.start[i] == tbl.start[j]) && (i < j));
	end

	// gap 0 follows the header, gap i+1 follows entry i
	always_comb begin
		for (int g = 0; g < G; g++)
			for (int h = 0; h < G; h++) begin
				if (g == h)      prec[g][h] = 1'b0;
				else if (g == 0) prec[g][h] = 1'b1;
				else if (h == 0) prec[g][h] = 1'b0;
				else             prec[g][h] = bef[g-1][h-1];
			end
	end

	always_comb begin
		logic seen;
		for (int g = 0; g < G; g++) begin
			if (g == 0)
				gstart[g] = {{(pta_pkg::END_W - pta_pkg::HDR_W){1'b0}}, tbl.header};
			else
				gstart[g] = {1'b0, tbl.start[g-1]} + {1'b0, tbl.length[g-1]};
			seen    = 1'b0;
			gend[g] = {1'b0, tbl.disk};
			// gap ends at the next live start in table order, else at disk end
			for (int j = 0; j < N; j++) begin
				if (tbl.live[j] && (g == 0 || (j != g - 1 && bef[g-1][j])) &&
					(!seen || {1'b0, tbl.start[j]} < gend[g])) begin
					gend[g] = {1'b0, tbl.start[j]};
					seen    = 1'b1;
				end
			end
			gsize[g] = {2'b0, gend[g]} - {2'b0, gstart[g]};
			gsz[g]   = gsize[g][pta_pkg::END_W:0];
			gok[g]   = (g == 0 || tbl.live[g-1]) && !gsize[g][pta_pkg::GAP_W-1] &&
				({{(pta_pkg::NEED_W - pta_pkg::END_W - 1){1'b0}}, gsz[g]} >= need);
		end
	end

	always_comb begin
		logic better;
		for (int g = 0; g < G; g++) begin
			win[g] = gok[g];
			for (int h = 0; h < G; h++) begin
				case (req.fit_mode)
					pta_pkg::FIT_BEST:  better = (gsz[g] < gsz[h]) ||
						((gsz[g] == gsz[h]) && prec[g][h]);
					pta_pkg::FIT_WORST: better = (gsz[g] > gsz[h]) ||
						((gsz[g] == gsz[h]) && prec[g][h]);
					default:            better = prec[g][h];
				endcase
				if (h != g && gok[h] && !better)
					win[g] = 1'b0;
			end
		end
	end

	always_comb begin
		pick_start = '0;
		for (int g = 0; g < G; g++)
			if (win[g])
				pick_start = pick_start | gstart[g];
	end

	assign any_fit = |win;

	always_comb begin
		dup        = 1'b0;
		ext_exists = 1'b0;
		found      = 1'b0;
		hit_slot   = '0;
		free_seen  = 1'b0;
		free_slot  = '0;
		for (int i = 0; i < N; i++) begin
			if (tbl.live[i] && tbl.name[i] == req.name_key) begin
				dup = 1'b1;
				if (!found) begin
					found    = 1'b1;
					hit_slot = pta_pkg::SLOT_W'(i);
				end
			end
			if (tbl.live[i] && tbl.ext[i])
				ext_exists = 1'b1;
			if (!tbl.live[i] && !free_seen) begin
				free_seen = 1'b1;
				free_slot = pta_pkg::SLOT_W'(i);
			end
		end
		full = !free_seen;
	end

	always_comb begin
		res = '0;
		wr  = '0;
		wr.slot   = free_slot;
		wr.start  = pick_start[pta_pkg::BYTE_W-1:0];
		wr.length = need[pta_pkg::BYTE_W-1:0];
		wr.ext    = req.kind;
		wr.name   = req.name_key;
		if (req.operation == pta_pkg::OP_LOOKUP) begin
			if (found) begin
				res.status       = pta_pkg::ST_OK;
				res.slot         = hit_slot;
				res.start_byte   = tbl.start[hit_slot];
				res.length_bytes = tbl.length[hit_slot];
				res.found_kind   = tbl.ext[hit_slot];
			end else begin
				res.status = pta_pkg::ST_NOT_FOUND;
			end
		end else if (req.size_value == '0 || req.name_key == '0) begin
			res.status = pta_pkg::ST_BAD;
		end else if (dup) begin
			res.status = pta_pkg::ST_DUPLICATE;
		end else if (full) begin
			res.status = pta_pkg::ST_FULL;
		end else if (req.kind && ext_exists) begin
			res.status = pta_pkg::ST_EXTENDED;
		end else if (!any_fit) begin
			res.status = pta_pkg::ST_NO_SPACE;
		end else begin
			wr.en            = 1'b1;
			res.status       = pta_pkg::ST_OK;
			res.slot         = free_slot;
			res.start_byte   = wr.start;
			res.length_bytes = wr.length;
			res.found_kind   = req.kind;
		end
	end

endmodule

@@ hw/rtl/pta_checker.sv @@
module pta_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pta_pkg::OUT_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("status code out of range");

	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != pta_pkg::ST_OK |-> m_tdata[67:3] == '0)
		else $error("failed request carries entry fields");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:68] == '0)
		else $error("result padding not zero");

endmodule

bind partition_table_fit_allocator pta_checker u_pta_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
